// ===== sv/swerve_steer_shortest_path_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the steering shortest-path block
// Each macro expands to a labeled concurrent assertion, or to nothing when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SWERVE_STEER_SHORTEST_PATH_DEFINES_SVH
`define SWERVE_STEER_SHORTEST_PATH_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("implication check failed");
// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ===== sv/swsp_pkg.sv =====
// ----------------------------------------------------------------------------
// swsp_pkg
// Widths, register codes, stage counts and the result record shared by the
// steering shortest-path block.
// ----------------------------------------------------------------------------
package swsp_pkg;

  // Field widths.
  localparam int AW  = 32;  // input angle width
  localparam int SW  = 16;  // wheel speed width
  localparam int RW  = 20;  // angle range register width
  localparam int ZW  = 16;  // dead zone register width
  localparam int SPW = 20;  // steering setpoint width

  // Wrapped angles hold either a raw angle or a value below the range.
  localparam int WW = (AW > RW) ? AW : RW + 1;
  // Angle differences and their magnitudes.
  localparam int DW = WW + 2;

  // Remainder pipeline: bits of the angle magnitude retired per stage.
  localparam int BPS = 4;
  localparam int MS  = (AW + BPS - 1) / BPS;
  localparam int MB  = MS * BPS;
  // Wrap unit stages: magnitude, remainder steps, sign fixup.
  localparam int NW  = MS + 2;
  // Decision stages after the wrap unit.
  localparam int NP  = 3;
  // All pipeline stages.
  localparam int NS  = NW + NP;

  // Stream widths.
  localparam int IN_TDATA_W  = ((2 * AW + SW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SPW + SW + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = RW;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_RANGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 1'd1;

  localparam logic [RW-1:0] ANGLE_RANGE_RESET = 20'd131072;
  localparam logic [ZW-1:0] DEAD_ZONE_RESET   = 16'd16;

  // Speed limits for saturating negation.
  localparam logic signed [SW-1:0] SPD_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SPD_MAX = {1'b0, {(SW-1){1'b1}}};

  // One steering decision.
  typedef struct packed {
    logic                  held;
    logic                  rev;
    logic signed [SW-1:0]  speed;
    logic [SPW-1:0]        setpoint;
  } result_t;

endpackage

// ===== sv/swerve_steer_shortest_path.sv =====
// ----------------------------------------------------------------------------
// swerve_steer_shortest_path
// Swerve module steering decision: wraps target and measured angles, holds
// inside the dead zone, otherwise picks the nearer of target and half-turn
// target and reverses the wheel speed when the half-turn target wins.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis (target, measured angle, wheel speed) and
//   results leave on m_axis (setpoint and speed in tdata, flags in tuser).
//   Configuration writes go through cfg_valid/cfg_index/cfg_data; cfg_ready
//   is always high. Registers should be written only while no request is in
//   flight.
//   A result passes 13 register stages in all, the last being the output
//   register. Throughput: one request per cycle until back-pressure fills
//   every stage. The depth is set by the remainder pipeline, which retires
//   4 bits of the 32-bit angle magnitude per stage over 8 stages, plus
//   magnitude, sign fixup and three decision stages.
//   Reset empties the pipeline and restores the range to 131072 and the
//   dead zone to 16.
//   When the receiver stalls, each stage holds its request; empty stages
//   still fill, and s_axis_tready drops only once every stage is occupied.
// ----------------------------------------------------------------------------
`include "swerve_steer_shortest_path_defines.svh"

module swerve_steer_shortest_path (
  input  logic                                clk,
  input  logic                                rst,
  // Request channel.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] target_angle, [63:32] measured_angle, [79:64] wheel_speed
  input  logic [swsp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Result channel.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [19:0] steer_setpoint, [35:20] speed_out, [39:36] zero
  output logic [swsp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] reversed, [1] held
  output logic [1:0]                          m_axis_tuser,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swsp_pkg::CFG_DW-1:0]         cfg_data
);

  logic [swsp_pkg::RW-1:0]        angle_range;
  logic [swsp_pkg::ZW-1:0]        dead_zone;
  logic [swsp_pkg::NS-1:0]        valid;
  logic [swsp_pkg::NS:0]          en;
  logic signed [swsp_pkg::SW-1:0] spd_q [swsp_pkg::NW];
  logic signed [swsp_pkg::WW-1:0] wt_w, wf_w;
  swsp_pkg::result_t              res;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_range <= swsp_pkg::ANGLE_RANGE_RESET;
      dead_zone   <= swsp_pkg::DEAD_ZONE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        swsp_pkg::REG_ANGLE_RANGE: angle_range <= cfg_data[swsp_pkg::RW-1:0];
        swsp_pkg::REG_DEAD_ZONE:   dead_zone   <= cfg_data[swsp_pkg::ZW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor moves.
  always_comb begin
    en[swsp_pkg::NS] = m_axis_tready;
    for (int k = swsp_pkg::NS - 1; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < swsp_pkg::NS; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // Wheel speed rides alongside the wrap units.
  for (genvar k = 0; k < swsp_pkg::NW; k++) begin : g_spd
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[0]) begin
          spd_q[0] <= s_axis_tdata[2*swsp_pkg::AW +: swsp_pkg::SW];
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en[k]) begin
          spd_q[k] <= spd_q[k-1];
        end
      end
    end
  end

  // Wrap units for the two angles.
  swsp_wrap u_wrap_target (
    .clk     (clk),
    .en      (en[swsp_pkg::NW-1:0]),
    .range   (angle_range),
    .angle   (s_axis_tdata[swsp_pkg::AW-1:0]),
    .wrapped (wt_w)
  );

  swsp_wrap u_wrap_measured (
    .clk     (clk),
    .en      (en[swsp_pkg::NW-1:0]),
    .range   (angle_range),
    .angle   (s_axis_tdata[swsp_pkg::AW +: swsp_pkg::AW]),
    .wrapped (wf_w)
  );

  // Decision stages, ending in the output register.
  swsp_pick u_pick (
    .clk       (clk),
    .en        (en[swsp_pkg::NS-1:swsp_pkg::NW]),
    .range     (angle_range),
    .dead_zone (dead_zone),
    .wt        (wt_w),
    .wf        (wf_w),
    .speed     (spd_q[swsp_pkg::NW-1]),
    .res       (res)
  );

  // Output packing.
  assign m_axis_tvalid = valid[swsp_pkg::NS-1];
  assign m_axis_tdata  = {{(swsp_pkg::OUT_TDATA_W - swsp_pkg::SPW - swsp_pkg::SW){1'b0}},
                          res.speed, res.setpoint};
  assign m_axis_tuser  = {res.held, res.rev};

  // Input is refused only when every stage holds a request.
  `ASSERT_IMPLIES(a_full_when_refused, clk, rst, !s_axis_tready, &valid)
  // A stalled wrap output keeps its angle.
  `ASSERT_NEXT(a_wrap_hold, clk, rst, valid[swsp_pkg::NW-1] && !en[swsp_pkg::NW-1],
               $stable(wt_w) && $stable(wf_w))
  // A held result is never also reversed.
  `ASSERT_IMPLIES(a_held_not_rev, clk, rst, m_axis_tvalid, !(res.held && res.rev))

endmodule

// ===== sv/swsp_wrap.sv =====
// ----------------------------------------------------------------------------
// swsp_wrap
// Pipelined wrap of a signed angle into [0, range): magnitude, a restoring
// remainder over several stages, then the sign fixup. Range zero passes the
// raw angle through.
// ----------------------------------------------------------------------------
module swsp_wrap (
  input  logic                             clk,
  input  logic [swsp_pkg::NW-1:0]          en,
  input  logic [swsp_pkg::RW-1:0]          range,
  input  logic signed [swsp_pkg::AW-1:0]   angle,
  output logic signed [swsp_pkg::WW-1:0]   wrapped
);

  // Retire one chunk of dividend bits into the running remainder.
  function automatic logic [swsp_pkg::RW-1:0] mod_chunk(
    input logic [swsp_pkg::RW-1:0]  rem_in,
    input logic [swsp_pkg::BPS-1:0] chunk,
    input logic [swsp_pkg::RW-1:0]  r
  );
    logic [swsp_pkg::RW:0] acc;
    acc = {1'b0, rem_in};
    for (int i = swsp_pkg::BPS - 1; i >= 0; i--) begin
      acc = {acc[swsp_pkg::RW-1:0], chunk[i]};
      if (acc >= {1'b0, r}) begin
        acc = acc - {1'b0, r};
      end
    end
    return acc[swsp_pkg::RW-1:0];
  endfunction

  logic [swsp_pkg::RW-1:0]        rem_q [swsp_pkg::MS+1];
  logic [swsp_pkg::MB-1:0]        bits_q [swsp_pkg::MS];
  logic                           neg_q [swsp_pkg::MS+1];
  logic signed [swsp_pkg::AW-1:0] raw_q [swsp_pkg::MS+1];
  logic [swsp_pkg::AW-1:0]        mag;

  // Magnitude of the input angle; the most negative value maps to its
  // unsigned magnitude.
  assign mag = angle[swsp_pkg::AW-1] ? swsp_pkg::AW'(-angle) : swsp_pkg::AW'(angle);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_q[0]  <= '0;
      bits_q[0] <= swsp_pkg::MB'(mag);
      neg_q[0]  <= angle[swsp_pkg::AW-1];
      raw_q[0]  <= angle;
    end
  end

  // Remainder stages, most significant chunk first.
  for (genvar j = 1; j <= swsp_pkg::MS; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_q[j]  <= mod_chunk(rem_q[j-1],
                               bits_q[j-1][swsp_pkg::MB-1 -: swsp_pkg::BPS], range);
        neg_q[j]  <= neg_q[j-1];
        raw_q[j]  <= raw_q[j-1];
      end
    end
  end

  // Dividend bits still to be retired; the last stage needs none.
  for (genvar j = 1; j < swsp_pkg::MS; j++) begin : g_bits
    always_ff @(posedge clk) begin
      if (en[j]) begin
        bits_q[j] <= bits_q[j-1] << swsp_pkg::BPS;
      end
    end
  end

  // Sign fixup: a negative angle with a nonzero remainder lands at range - rem.
  always_ff @(posedge clk) begin
    if (en[swsp_pkg::NW-1]) begin
      if (range == '0) begin
        wrapped <= swsp_pkg::WW'(raw_q[swsp_pkg::MS]);
      end else if (neg_q[swsp_pkg::MS] && (rem_q[swsp_pkg::MS] != '0)) begin
        wrapped <= signed'(swsp_pkg::WW'(range - rem_q[swsp_pkg::MS]));
      end else begin
        wrapped <= signed'(swsp_pkg::WW'(rem_q[swsp_pkg::MS]));
      end
    end
  end

endmodule

// ===== sv/swsp_pick.sv =====
// ----------------------------------------------------------------------------
// swsp_pick
// Three-stage decision: shortest deltas to the target and to the half-turn
// target, their magnitudes, then dead zone, selection and speed reversal.
// ----------------------------------------------------------------------------
module swsp_pick (
  input  logic                            clk,
  input  logic [swsp_pkg::NP-1:0]         en,
  input  logic [swsp_pkg::RW-1:0]         range,
  input  logic [swsp_pkg::ZW-1:0]         dead_zone,
  input  logic signed [swsp_pkg::WW-1:0]  wt,
  input  logic signed [swsp_pkg::WW-1:0]  wf,
  input  logic signed [swsp_pkg::SW-1:0]  speed,
  output swsp_pkg::result_t               res
);

  // Fold a delta into [-half, half] by one range step.
  function automatic logic signed [swsp_pkg::DW-1:0] fold(
    input logic signed [swsp_pkg::DW-1:0] d,
    input logic signed [swsp_pkg::DW-1:0] r,
    input logic signed [swsp_pkg::DW-1:0] h
  );
    logic signed [swsp_pkg::DW-1:0] o;
    o = d;
    if (d > h) begin
      o = d - r;
    end else if (d < -h) begin
      o = d + r;
    end
    return o;
  endfunction

  function automatic logic signed [swsp_pkg::DW-1:0] absv(
    input logic signed [swsp_pkg::DW-1:0] v
  );
    return (v < 0) ? -v : v;
  endfunction

  logic signed [swsp_pkg::DW-1:0] rr, half, dz, rt0, rt_n, mrd;
  logic signed [swsp_pkg::DW-1:0] dd_a, rt_a, wt_a, wf_a;
  logic signed [swsp_pkg::DW-1:0] rd_b, mdd_b, rt_b, wt_b, wf_b;
  logic signed [swsp_pkg::SW-1:0] spd_a, spd_b;
  logic signed [swsp_pkg::DW-1:0] sel;
  logic                           held_c, rev_c;

  assign rr   = signed'(swsp_pkg::DW'(range));
  assign half = signed'(swsp_pkg::DW'(range >> 1));
  assign dz   = signed'(swsp_pkg::DW'(dead_zone));

  // Half-turn target, wrapped back below the range.
  assign rt0  = swsp_pkg::DW'(wt) + half;
  assign rt_n = (rt0 >= rr) ? rt0 - rr : rt0;

  // Stage A: direct shortest delta and reversed target.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dd_a  <= fold(swsp_pkg::DW'(wt) - swsp_pkg::DW'(wf), rr, half);
      rt_a  <= rt_n;
      wt_a  <= swsp_pkg::DW'(wt);
      wf_a  <= swsp_pkg::DW'(wf);
      spd_a <= speed;
    end
  end

  // Stage B: reversed shortest delta and direct magnitude.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      rd_b  <= fold(rt_a - wf_a, rr, half);
      mdd_b <= absv(dd_a);
      rt_b  <= rt_a;
      wt_b  <= wt_a;
      wf_b  <= wf_a;
      spd_b <= spd_a;
    end
  end

  // Stage C: dead zone, strict comparison, selection.
  assign mrd    = absv(rd_b);
  assign held_c = (mdd_b <= dz);
  assign rev_c  = !held_c && (mrd < mdd_b);
  assign sel    = held_c ? wf_b : (rev_c ? rt_b : wt_b);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res.held     <= held_c;
      res.rev      <= rev_c;
      res.setpoint <= sel[swsp_pkg::SPW-1:0];
      if (!rev_c) begin
        res.speed <= spd_b;
      end else if (spd_b == swsp_pkg::SPD_MIN) begin
        res.speed <= swsp_pkg::SPD_MAX;
      end else begin
        res.speed <= -spd_b;
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the steering shortest-path block
// Drives steering requests through the stream input, writes the range and
// dead-zone registers between phases, and checks every decision on the result
// stream against directed values or an in-bench wrap/dead-zone/half-turn model.
// ----------------------------------------------------------------------------
module testbench;
  import swsp_pkg::*;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

  // One line of the directed stimulus.
  typedef struct {
    row_kind_t             kind;
    logic signed [AW-1:0]  tgt;
    logic signed [AW-1:0]  meas;
    logic signed [SW-1:0]  spd;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DW-1:0]     data;
    bit                    known;
    result_t               want;
  } steer_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DW-1:0]      cfg_data;

  // Register copies used by the decision model.
  logic [RW-1:0] turn_range = ANGLE_RANGE_RESET;
  logic [ZW-1:0] dead_band  = DEAD_ZONE_RESET;

  result_t    pending_decisions[$];
  steer_row_t directed_rows[$];
  int         mismatches = 0;
  bit         steady = 1'b0;
  bit         hold_request = 1'b0;

  swerve_steer_shortest_path dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Angle wrapped into [0, range); a zero range leaves it as it is.
  function automatic longint wrap_turn(input longint a, input longint r);
    longint x;
    if (r <= 0) return a;
    x = a % r;
    if (x < 0) x += r;
    return x;
  endfunction

  // Signed difference t - f folded into [-half, half].
  function automatic longint shortest_delta(input longint t, input longint f,
                                            input longint r);
    longint d;
    d = t - f;
    if (d > r / 2) d -= r;
    else if (d < -(r / 2)) d += r;
    return d;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Expected decision for one request under the current registers.
  function automatic result_t steer_decision(input logic signed [AW-1:0] tgt,
                                             input logic signed [AW-1:0] meas,
                                             input logic signed [SW-1:0] spd);
    longint  r, half, zone, wt, wf, rt, dd, rd, sel;
    result_t res;
    r    = longint'(turn_range);
    half = r / 2;
    zone = longint'(dead_band);
    wt   = wrap_turn(longint'(tgt), r);
    wf   = wrap_turn(longint'(meas), r);
    rt   = wrap_turn(wt + half, r);
    dd   = shortest_delta(wt, wf, r);
    rd   = shortest_delta(rt, wf, r);
    res.speed = spd;
    res.rev   = 1'b0;
    res.held  = 1'b0;
    if (magnitude(dd) <= zone) begin
      sel = wf;
      res.held = 1'b1;
    end else if (magnitude(rd) < magnitude(dd)) begin
      sel = rt;
      res.rev = 1'b1;
      res.speed = (spd == SPD_MIN) ? SPD_MAX : -spd;
    end else begin
      sel = wt;
    end
    res.setpoint = sel[SPW-1:0];
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int jitter();
    return int'($urandom_range(0, 4)) - 2;
  endfunction

  function void add_request(input logic signed [AW-1:0] tgt,
                            input logic signed [AW-1:0] meas,
                            input logic signed [SW-1:0] spd);
    steer_row_t row;
    row = '{kind: ROW_REQUEST, tgt: tgt, meas: meas, spd: spd, idx: '0, data: '0,
            known: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  function void add_checked(input logic signed [AW-1:0] tgt,
                            input logic signed [AW-1:0] meas,
                            input logic signed [SW-1:0] spd,
                            input logic [SPW-1:0] sp, input logic signed [SW-1:0] so,
                            input logic rev, input logic held);
    steer_row_t row;
    row = '{kind: ROW_REQUEST, tgt: tgt, meas: meas, spd: spd, idx: '0, data: '0,
            known: 1'b1, want: '{held: held, rev: rev, speed: so, setpoint: sp}};
    directed_rows.push_back(row);
  endfunction

  function void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    steer_row_t row;
    row = '{kind: ROW_WRITE, tgt: '0, meas: '0, spd: '0, idx: idx, data: data,
            known: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  // Random request shaped around the current range and dead zone.
  function automatic void random_request(output logic signed [AW-1:0] tgt,
                                         output logic signed [AW-1:0] meas,
                                         output logic signed [SW-1:0] spd);
    longint r, half, base, delta;
    r    = longint'(turn_range);
    half = r / 2;
    case ($urandom_range(0, 9))
      0, 1, 2:    base = longint'($signed($urandom));
      3, 4, 5, 6: base = (longint'($urandom_range(0, 8)) - 4) * r
                         + longint'($urandom_range(0, int'(r)));
      default:    base = (r == 0) ? longint'($urandom_range(0, 20'hFFFFF))
                                  : longint'($urandom_range(0, int'(r) - 1));
    endcase
    // Offsets cluster at the dead-zone edge, the tie point and the half turn.
    case ($urandom_range(0, 4))
      0:       delta = longint'(dead_band) + jitter();
      1:       delta = half / 2 + jitter();
      2:       delta = half + jitter();
      3:       delta = (half == 0) ? longint'($urandom_range(0, 255))
                                   : longint'($urandom_range(0, int'(half)));
      default: delta = longint'($signed($urandom));
    endcase
    if ($urandom_range(0, 1)) delta = -delta;
    meas = AW'(base);
    tgt  = AW'(base + delta + (longint'($urandom_range(0, 4)) - 2) * r);
    case ($urandom_range(0, 19))
      0, 1:    spd = SPD_MIN;
      2:       spd = SPD_MAX;
      3:       spd = '0;
      default: spd = SW'($urandom);
    endcase
  endfunction

  // Offer one request and wait for it to be taken.
  task automatic send_request(input logic signed [AW-1:0] tgt,
                              input logic signed [AW-1:0] meas,
                              input logic signed [SW-1:0] spd,
                              input bit known, input result_t want);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {spd, meas, tgt};
    do @(posedge clk); while (!s_axis_tready);
    pending_decisions.push_back(known ? want : steer_decision(tgt, meas, spd));
  endtask

  task automatic stop_requests();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pending_decisions.size() != 0) @(posedge clk);
  endtask

  // Register write, only with the pipeline empty.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DW-1:0] data);
    stop_requests();
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ANGLE_RANGE) turn_range = data[RW-1:0];
    else dead_band = data[ZW-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side: random back-pressure plus one long hold on request.
  initial begin : result_sink
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = 80;
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Compare each delivered decision with the oldest one predicted.
  initial begin : result_check
    result_t              want;
    logic [SPW-1:0]       got_sp;
    logic signed [SW-1:0] got_spd;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got_sp  = m_axis_tdata[SPW-1:0];
        got_spd = m_axis_tdata[SPW+SW-1:SPW];
        if (pending_decisions.size() == 0) begin
          $error("unexpected result: setpoint %0d speed %0d", got_sp, got_spd);
          mismatches++;
        end else begin
          want = pending_decisions.pop_front();
          if (got_sp !== want.setpoint) begin
            $error("steer_setpoint: expected %0d, got %0d", want.setpoint, got_sp);
            mismatches++;
          end
          if (got_spd !== want.speed) begin
            $error("speed_out: expected %0d, got %0d", want.speed, got_spd);
            mismatches++;
          end
          if (m_axis_tuser[0] !== want.rev) begin
            $error("reversed: expected %0b, got %0b", want.rev, m_axis_tuser[0]);
            mismatches++;
          end
          if (m_axis_tuser[1] !== want.held) begin
            $error("held: expected %0b, got %0b", want.held, m_axis_tuser[1]);
            mismatches++;
          end
        end
      end
    end
  end

  // Main sequence: reset, directed rows, random phases, wind-down.
  initial begin : stimulus
    logic [RW-1:0]        phase_range [9];
    logic [CFG_DW-1:0]    phase_zone  [9];
    logic signed [AW-1:0] tgt, meas;
    logic signed [SW-1:0] spd;
    int                   per_phase;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ANGLE_RANGE;
    cfg_data      = '0;

    // Directed rows under the reset registers.
    add_checked(0, 0, 100, 0, 100, 1'b0, 1'b1);
    add_checked(16, 0, 9, 0, 9, 1'b0, 1'b1);
    add_checked(17, 0, -5, 17, -5, 1'b0, 1'b0);
    add_checked(-1, 0, 7, 0, 7, 1'b0, 1'b1);
    add_checked(131077, -3, 1234, 131069, 1234, 1'b0, 1'b1);
    add_checked(65536, 0, SPD_MIN, 0, SPD_MAX, 1'b1, 1'b0);
    add_checked(32768, 0, 42, 32768, 42, 1'b0, 1'b0);
    add_request(32769, 0, -300);
    add_request(70000, 0, SPD_MAX);
    add_request(32'h7FFFFFFF, 32'h80000000, SPD_MAX);
    add_request(32'h80000000, 32'h7FFFFFFF, -1);
    add_request(-65536, 65536, SPD_MIN);
    // Zero dead zone.
    add_write(REG_DEAD_ZONE, 0);
    add_checked(0, 0, -2, 0, -2, 1'b0, 1'b1);
    add_request(1, 0, 3);
    // Zero range: no wrapping and no reversal.
    add_write(REG_ANGLE_RANGE, 0);
    add_checked(-1, 5, SPD_MIN, 20'hFFFFF, SPD_MIN, 1'b0, 1'b0);
    add_request(32'h7FFFFFFF, 32'h80000000, 11);
    add_checked(7, 7, 1, 7, 1, 1'b0, 1'b1);
    // Largest range and dead zone; the upper data bits are dropped for the zone.
    add_write(REG_ANGLE_RANGE, 20'hFFFFF);
    add_write(REG_DEAD_ZONE, 20'hFFFFF);
    add_checked(0, 65535, 77, 65535, 77, 1'b0, 1'b1);
    add_checked(0, 65536, 77, 0, 77, 1'b0, 1'b0);

    phase_range = '{0, 20'hFFFFF, 1, 2, 5760, 0, 0, 0, ANGLE_RANGE_RESET};
    phase_zone  = '{0, 16'hFFFF, 0, 0, 16, 16'hFFFF, 0, 0, DEAD_ZONE_RESET};
    phase_range[6] = RW'($urandom_range(3, 4096));
    phase_zone[6]  = CFG_DW'($urandom_range(0, 8));
    phase_range[7] = RW'($urandom_range(3, 20'hFFFFF));
    phase_zone[7]  = CFG_DW'($urandom_range(0, 20'hFFFFF));
    per_phase = 67;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE)
        write_register(directed_rows[i].idx, directed_rows[i].data);
      else
        send_request(directed_rows[i].tgt, directed_rows[i].meas, directed_rows[i].spd,
                     directed_rows[i].known, directed_rows[i].want);
    end

    for (int p = 0; p < 9; p++) begin
      write_register(REG_ANGLE_RANGE, phase_range[p]);
      write_register(REG_DEAD_ZONE, phase_zone[p]);
      steady = (p == 4) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < per_phase; n++) begin
        // Mid-phase, the result side stops while requests keep coming.
        if (p == 4 && n == 20) hold_request = 1'b1;
        random_request(tgt, meas, spd);
        send_request(tgt, meas, spd, 1'b0, '0);
      end
    end

    stop_requests();
    drain();
    repeat (NS + 4) @(posedge clk);
    if (mismatches == 0 && pending_decisions.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/swsp_pkg.sv
sv/swsp_wrap.sv
sv/swsp_pick.sv
sv/swerve_steer_shortest_path.sv
tb/testbench.sv
